/* rtl/ffsa_pkg.sv */
// Shared types and constants of the first-fit segment allocator.
// Used by every module in this folder; depends on nothing else.
package ffsa_pkg;

   localparam int ADDR_BITS    = 20;
   localparam int ADDR_W       = 20;
   localparam int SIZE_W       = 21;
   localparam int NEED_W       = 22;
   localparam int SUM_W        = 23;
   localparam int HEADER_BYTES = 32;
   localparam int ALIGN_BYTES  = 16;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [NEED_W-1:0] ALIGN_LOW = NEED_W'(ALIGN_BYTES - 1);
   localparam logic [SIZE_W-1:0] POOL_CAP = SIZE_W'(64'd1 << ADDR_BITS);
   localparam logic [SIZE_W-1:0] LIMIT_RESET = SIZE_W'(1048576);

   localparam logic REG_POOL_LIMIT = 1'b0;

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_FREE    = 2'd1;
   localparam logic [1:0] OP_REALLOC = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOMEM    = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;

   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_ALLOC   = 2'd1;
   localparam logic [1:0] KIND_FREE    = 2'd2;
   localparam logic [1:0] KIND_REALLOC = 2'd3;

   typedef struct packed {
      logic [ADDR_W-1:0] offset;
      logic [SIZE_W-1:0] size;
      logic              free;
   } seg_type;

   typedef struct packed {
      logic pop;
      logic load;
   } cell_ctl_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [SIZE_W-1:0] request_bytes;
      logic [ADDR_W-1:0] user_addr;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] result_addr;
      logic [1:0]        status;
      logic              moved;
      logic [SIZE_W-1:0] copy_bytes;
   } rsp_type;

endpackage

/* rtl/first_fit_segment_allocator.sv */
// Top level of the first-fit segment allocator: sequencer, pool state and cell queue.
// Instantiates ffsa_cell and ffsa_csr; uses ffsa_pkg.
//
// Requests arrive on the req_ channel (valid/ready) and each gives exactly one
// result on the rsp_ channel. The segment table lives in a row of cells that
// forms a queue; every pass rotates all entries once through the head cell.
// A request takes a read pass to find the target and first fit, a decision
// state, and for a changing request a rewrite pass that splits, marks and
// merges segments on the fly, then flushes the last pending entry and, for an
// append, pushes the new segment. One request is in work at a time, and
// req_ready is high only when the sequencer is idle. The result waits in an
// output register; while the receiver stalls, the finished request holds until
// the transfer completes. Reset empties the table, clears the pool top and
// sets the pool limit to its full value. The user must write the pool limit
// through the APB-style port while idle; the block itself does not
// enforce this.
module first_fit_segment_allocator #(
   parameter int MAX_SEGMENTS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  ffsa_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output ffsa_pkg::rsp_type               rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [ffsa_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [ffsa_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ffsa_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import ffsa_pkg::*;

   localparam int LEN_W = $clog2(MAX_SEGMENTS + 1);
   localparam int IDX_W = $clog2(MAX_SEGMENTS);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_SEGMENTS);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_MODIFY = 3'd3;
   localparam logic [2:0] S_FLUSH  = 3'd4;
   localparam logic [2:0] S_APPEND = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;

   logic [SIZE_W-1:0] pool_limit;

   seg_type      cell_q [MAX_SEGMENTS];
   cell_ctl_type ctl [MAX_SEGMENTS];
   seg_type      push_seg;
   seg_type      head;
   logic         pop;
   logic         push;
   logic [LEN_W-1:0] tail;

   logic [2:0]        state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  pass_len_ff, pass_len_in;
   logic [LEN_W-1:0]  k_ff, k_in;
   logic [SIZE_W-1:0] pool_top_ff, pool_top_in;
   logic [1:0]        kind_ff, kind_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              ff_hit_ff, ff_hit_in;
   logic [IDX_W-1:0]  ff_idx_ff, ff_idx_in;
   logic [ADDR_W-1:0] ff_off_ff, ff_off_in;
   logic              fa_hit_ff, fa_hit_in;
   logic [IDX_W-1:0]  fa_idx_ff, fa_idx_in;
   logic [SIZE_W-1:0] old_ff, old_in;
   logic              cap_next_ff, cap_next_in;
   logic              nx_v_ff, nx_v_in;
   logic              nx_free_ff, nx_free_in;
   logic [SIZE_W-1:0] nx_size_ff, nx_size_in;
   logic              take_ff, take_in;
   logic [IDX_W-1:0]  take_idx_ff, take_idx_in;
   logic              mfree_ff, mfree_in;
   logic              absorb_ff, absorb_in;
   logic              append_ff, append_in;
   logic              pend_v_ff, pend_v_in;
   seg_type           pend_ff, pend_in;
   logic              hold_v_ff, hold_v_in;
   seg_type           hold_ff, hold_in;
   logic              arm_ff, arm_in;
   rsp_type           res_ff, res_in;
   logic              rsp_v_ff, rsp_v_in;
   rsp_type           rsp_ff, rsp_in;

   logic [IDX_W-1:0]  k_idx;
   logic [NEED_W-1:0] req_need;
   logic [SIZE_W-1:0] lim;
   logic              a_room;
   logic              a_ok;
   logic [ADDR_W-1:0] a_addr;
   logic              r_big;
   logic              r_fits;
   logic              r_grow;
   logic              split_ok;
   logic              emit_en;
   logic              arm_set;
   seg_type           emit_seg;

   ffsa_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pool_limit (pool_limit)
   );

   assign pready = 1'b1;

   for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
      seg_type right_seg;
      if (i == MAX_SEGMENTS - 1) begin : g_last
         assign right_seg = push_seg;
      end else begin : g_mid
         assign right_seg = cell_q[i+1];
      end
      assign ctl[i].pop  = pop;
      assign ctl[i].load = push && (tail == LEN_W'(i));
      ffsa_cell u_cell (
         .clock     (clock),
         .ctl       (ctl[i]),
         .right_seg (right_seg),
         .push_seg  (push_seg),
         .seg       (cell_q[i])
      );
   end

   assign head     = cell_q[0];
   assign k_idx    = k_ff[IDX_W-1:0];
   assign tail     = pop ? (len_ff - LEN_W'(1)) : len_ff;
   assign req_need = (NEED_W'(req_data.request_bytes) + ALIGN_LOW) & ~ALIGN_LOW;

   assign lim    = (pool_limit < POOL_CAP) ? pool_limit : POOL_CAP;
   assign a_room = (len_ff < LEN_MAX) &&
                   ((SUM_W'(pool_top_ff) + SUM_W'(HEADER_BYTES) + SUM_W'(need_ff))
                    <= SUM_W'(lim));
   assign a_ok   = ff_hit_ff || a_room;
   assign a_addr = ff_hit_ff ? (ff_off_ff + ADDR_W'(HEADER_BYTES))
                             : (pool_top_ff[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES));
   assign r_big  = SUM_W'(old_ff) >= (SUM_W'(need_ff) + SUM_W'(HEADER_BYTES + ALIGN_BYTES));
   assign r_fits = SUM_W'(old_ff) >= SUM_W'(need_ff);
   assign r_grow = nx_v_ff && nx_free_ff &&
                   ((SUM_W'(old_ff) + SUM_W'(HEADER_BYTES) + SUM_W'(nx_size_ff))
                    >= SUM_W'(need_ff));
   assign split_ok = (SUM_W'(head.size) >=
                      (SUM_W'(need_ff) + SUM_W'(HEADER_BYTES + ALIGN_BYTES))) &&
                     (pass_len_ff < LEN_MAX);

   always_comb begin
      state_in    = state_ff;
      len_in      = len_ff;
      pass_len_in = pass_len_ff;
      k_in        = k_ff;
      pool_top_in = pool_top_ff;
      kind_in     = kind_ff;
      need_in     = need_ff;
      addr_in     = addr_ff;
      ff_hit_in   = ff_hit_ff;
      ff_idx_in   = ff_idx_ff;
      ff_off_in   = ff_off_ff;
      fa_hit_in   = fa_hit_ff;
      fa_idx_in   = fa_idx_ff;
      old_in      = old_ff;
      cap_next_in = cap_next_ff;
      nx_v_in     = nx_v_ff;
      nx_free_in  = nx_free_ff;
      nx_size_in  = nx_size_ff;
      take_in     = take_ff;
      take_idx_in = take_idx_ff;
      mfree_in    = mfree_ff;
      absorb_in   = absorb_ff;
      append_in   = append_ff;
      pend_v_in   = pend_v_ff;
      pend_in     = pend_ff;
      hold_v_in   = hold_v_ff;
      hold_in     = hold_ff;
      arm_in      = arm_ff;
      res_in      = res_ff;
      rsp_v_in    = rsp_v_ff && !rsp_ready;
      rsp_in      = rsp_ff;
      pop         = 1'b0;
      push        = 1'b0;
      push_seg    = head;
      emit_en     = 1'b0;
      arm_set     = 1'b0;
      emit_seg    = head;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               need_in     = req_need;
               addr_in     = req_data.user_addr;
               k_in        = '0;
               pass_len_in = len_ff;
               ff_hit_in   = 1'b0;
               fa_hit_in   = 1'b0;
               cap_next_in = 1'b0;
               nx_v_in     = 1'b0;
               unique case (req_data.op)
                  OP_ALLOC: kind_in = (req_data.request_bytes != '0) ? KIND_ALLOC : KIND_NONE;
                  OP_FREE:  kind_in = (req_data.user_addr != '0) ? KIND_FREE : KIND_NONE;
                  OP_REALLOC: begin
                     priority if (req_data.user_addr == '0) begin
                        kind_in = (req_data.request_bytes != '0) ? KIND_ALLOC : KIND_NONE;
                     end else if (req_data.request_bytes == '0) begin
                        kind_in = KIND_FREE;
                     end else begin
                        kind_in = KIND_REALLOC;
                     end
                  end
                  default: kind_in = KIND_NONE;
               endcase
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (k_ff < pass_len_ff) begin
               pop  = 1'b1;
               push = 1'b1;
               k_in = k_ff + LEN_W'(1);
               if (cap_next_ff) begin
                  cap_next_in = 1'b0;
                  nx_v_in     = 1'b1;
                  nx_free_in  = head.free;
                  nx_size_in  = head.size;
               end
               if (!ff_hit_ff && head.free && (NEED_W'(head.size) >= need_ff)) begin
                  ff_hit_in = 1'b1;
                  ff_idx_in = k_idx;
                  ff_off_in = head.offset;
               end
               if (!fa_hit_ff && !head.free &&
                   ((SIZE_W'(head.offset) + SIZE_W'(HEADER_BYTES)) == SIZE_W'(addr_ff))) begin
                  fa_hit_in   = 1'b1;
                  fa_idx_in   = k_idx;
                  old_in      = head.size;
                  cap_next_in = 1'b1;
               end
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            res_in      = '0;
            take_in     = 1'b0;
            take_idx_in = ff_idx_ff;
            mfree_in    = 1'b0;
            absorb_in   = 1'b0;
            append_in   = 1'b0;
            unique case (kind_ff)
               KIND_NONE: begin
                  res_in.status = ST_OK;
               end
               KIND_ALLOC: begin
                  if (a_ok) begin
                     take_in            = ff_hit_ff;
                     append_in          = !ff_hit_ff;
                     res_in.result_addr = a_addr;
                  end else begin
                     res_in.status = ST_NOMEM;
                  end
               end
               KIND_FREE: begin
                  if (fa_hit_ff) begin
                     mfree_in = 1'b1;
                  end else begin
                     res_in.status = ST_NOTFOUND;
                  end
               end
               KIND_REALLOC: begin
                  priority if (!fa_hit_ff) begin
                     res_in.status = ST_NOTFOUND;
                  end else if (r_big) begin
                     take_in            = 1'b1;
                     take_idx_in        = fa_idx_ff;
                     res_in.result_addr = addr_ff;
                  end else if (r_fits) begin
                     res_in.result_addr = addr_ff;
                  end else if (r_grow) begin
                     absorb_in          = 1'b1;
                     res_in.result_addr = addr_ff;
                  end else if (a_ok) begin
                     take_in            = ff_hit_ff;
                     append_in          = !ff_hit_ff;
                     mfree_in           = 1'b1;
                     res_in.result_addr = a_addr;
                     res_in.moved       = 1'b1;
                     res_in.copy_bytes  = old_ff;
                  end else begin
                     res_in.status = ST_NOMEM;
                  end
               end
               default: res_in = '0;
            endcase
            k_in      = '0;
            pend_v_in = 1'b0;
            hold_v_in = 1'b0;
            arm_in    = 1'b0;
            state_in  = S_FINISH;
            if (take_in || mfree_in || absorb_in || append_in) begin
               state_in = S_MODIFY;
            end
         end
         S_MODIFY: begin
            priority if (hold_v_ff) begin
               emit_en   = 1'b1;
               emit_seg  = hold_ff;
               hold_v_in = 1'b0;
            end else if (k_ff < pass_len_ff) begin
               pop      = 1'b1;
               emit_en  = 1'b1;
               emit_seg = head;
               k_in     = k_ff + LEN_W'(1);
               if (take_ff && (k_idx == take_idx_ff)) begin
                  emit_seg.free = 1'b0;
                  if (split_ok) begin
                     emit_seg.size  = need_ff[SIZE_W-1:0];
                     hold_v_in      = 1'b1;
                     hold_in.offset = head.offset + ADDR_W'(HEADER_BYTES) +
                                      need_ff[ADDR_W-1:0];
                     hold_in.size   = head.size - need_ff[SIZE_W-1:0] -
                                      SIZE_W'(HEADER_BYTES);
                     hold_in.free   = 1'b1;
                  end
               end else if (mfree_ff && (k_idx == fa_idx_ff)) begin
                  emit_seg.free = 1'b1;
               end else if (absorb_ff && (k_idx == fa_idx_ff)) begin
                  arm_set = 1'b1;
               end
            end else begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            push      = pend_v_ff;
            push_seg  = pend_ff;
            pend_v_in = 1'b0;
            arm_in    = 1'b0;
            state_in  = append_ff ? S_APPEND : S_FINISH;
         end
         S_APPEND: begin
            push            = 1'b1;
            push_seg.offset = pool_top_ff[ADDR_W-1:0];
            push_seg.size   = need_ff[SIZE_W-1:0];
            push_seg.free   = 1'b0;
            pool_top_in     = pool_top_ff + SIZE_W'(HEADER_BYTES) + need_ff[SIZE_W-1:0];
            state_in        = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_v_ff || rsp_ready) begin
               rsp_v_in = 1'b1;
               rsp_in   = res_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (emit_en) begin
         if (pend_v_ff && (arm_ff || (pend_ff.free && emit_seg.free))) begin
            pend_in.size = pend_ff.size + SIZE_W'(HEADER_BYTES) + emit_seg.size;
            arm_in       = 1'b0;
         end else begin
            push      = pend_v_ff;
            push_seg  = pend_ff;
            pend_in   = emit_seg;
            pend_v_in = 1'b1;
         end
         if (arm_set) begin
            arm_in = 1'b1;
         end
      end

      len_in = len_ff - LEN_W'(pop) + LEN_W'(push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         len_ff      <= '0;
         pool_top_ff <= '0;
         pend_v_ff   <= 1'b0;
         hold_v_ff   <= 1'b0;
         arm_ff      <= 1'b0;
         rsp_v_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         len_ff      <= len_in;
         pool_top_ff <= pool_top_in;
         pend_v_ff   <= pend_v_in;
         hold_v_ff   <= hold_v_in;
         arm_ff      <= arm_in;
         rsp_v_ff    <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      pass_len_ff <= pass_len_in;
      k_ff        <= k_in;
      kind_ff     <= kind_in;
      need_ff     <= need_in;
      addr_ff     <= addr_in;
      ff_hit_ff   <= ff_hit_in;
      ff_idx_ff   <= ff_idx_in;
      ff_off_ff   <= ff_off_in;
      fa_hit_ff   <= fa_hit_in;
      fa_idx_ff   <= fa_idx_in;
      old_ff      <= old_in;
      cap_next_ff <= cap_next_in;
      nx_v_ff     <= nx_v_in;
      nx_free_ff  <= nx_free_in;
      nx_size_ff  <= nx_size_in;
      take_ff     <= take_in;
      take_idx_ff <= take_idx_in;
      mfree_ff    <= mfree_in;
      absorb_ff   <= absorb_in;
      append_ff   <= append_in;
      pend_ff     <= pend_in;
      hold_ff     <= hold_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_MAX)
      else $error("Segment queue holds more entries than it has cells.");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!pend_v_ff && !hold_v_ff && !arm_ff))
      else $error("Rewrite pass left an entry outside the queue.");

   a_scan_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |=> $stable(len_ff))
      else $error("Read pass changed the number of segments.");

   a_hold_take: assert property (@(posedge clock) disable iff (reset)
      hold_v_ff |-> (take_ff && (state_ff == S_MODIFY)))
      else $error("Split remainder pending without a split.");

   a_top_cap: assert property (@(posedge clock) disable iff (reset)
      pool_top_ff <= POOL_CAP)
      else $error("Pool top beyond the address range.");

endmodule

/* rtl/ffsa_cell.sv */
// One cell of the segment queue: holds one segment descriptor.
// Takes its right neighbour's entry on a pop and the tail entry on a load; uses ffsa_pkg.
module ffsa_cell (
   input  logic                  clock,
   input  ffsa_pkg::cell_ctl_type ctl,
   input  ffsa_pkg::seg_type     right_seg,
   input  ffsa_pkg::seg_type     push_seg,
   output ffsa_pkg::seg_type     seg
);
   import ffsa_pkg::*;

   seg_type seg_ff;
   seg_type seg_in;

   always_comb begin
      seg_in = seg_ff;
      priority if (ctl.pop) begin
         seg_in = ctl.load ? push_seg : right_seg;
      end else if (ctl.load) begin
         seg_in = push_seg;
      end
   end

   always_ff @(posedge clock) begin
      seg_ff <= seg_in;
   end

   assign seg = seg_ff;

endmodule

/* rtl/ffsa_csr.sv */
// Configuration register file of the allocator: the pool limit register.
// APB-style write and read access; uses ffsa_pkg.
module ffsa_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [ffsa_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [ffsa_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ffsa_pkg::CSR_DATA_W-1:0] prdata,
   output logic [ffsa_pkg::SIZE_W-1:0]     pool_limit
);
   import ffsa_pkg::*;

   logic [SIZE_W-1:0] limit_ff;
   logic [SIZE_W-1:0] limit_in;
   logic              reg_index;

   assign reg_index = paddr[CSR_ADDR_W-1];

   always_comb begin
      limit_in = limit_ff;
      if (psel && penable && pwrite && (reg_index == REG_POOL_LIMIT)) begin
         limit_in = pwdata[SIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign prdata = (reg_index == REG_POOL_LIMIT) ?
                   {{(CSR_DATA_W - SIZE_W){1'b0}}, limit_ff} : '0;
   assign pool_limit = limit_ff;

endmodule
